// ----- sv/matrix_inverse_3x3_top_assert.svh -----
// Assertion macros used by the checker file of the 3x3 inverse block
`ifndef MATRIX_INVERSE_3X3_TOP_ASSERT_SVH
`define MATRIX_INVERSE_3X3_TOP_ASSERT_SVH

// plain property sampled on clk, off while reset is low
`define MI3_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mi3 check failed");

// implication form, antecedent and consequent in the same cycle
`define MI3_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mi3 check failed");

`endif

// ----- sv/mi3_pkg.sv -----
// Types and constants of the 3x3 fixed-point matrix inverse
package mi3_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// cofactor, determinant and divider widths
	localparam int CFW  = 2 * DATA_WIDTH + 1;
	localparam int PLW  = 2 * DATA_WIDTH + 1;
	localparam int DETW = 3 * DATA_WIDTH + 2;
	localparam int DAW  = 3 * DATA_WIDTH;
	localparam int NSW  = 2 * DATA_WIDTH + 2 * FRAC_BITS + 1;
	localparam int NW   = ((NSW > DAW) ? NSW : DAW) + 1;
	localparam int CW   = (NW > 4 * DATA_WIDTH + 2) ? NW : 4 * DATA_WIDTH + 2;
	localparam int QW   = DATA_WIDTH + 1;

	// cycles from the accepting edge to the edge that samples done
	localparam int PIPE_LAT = QW + 9;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;
	typedef logic signed [CFW-1:0]        cof_t;

	localparam elem_t ID_ONE = (FRAC_BITS < DATA_WIDTH - 1) ?
		elem_t'(DATA_WIDTH'(1) << FRAC_BITS) : elem_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});

	typedef struct packed {
		elem_t e_r0c0;
		elem_t e_r1c0;
		elem_t e_r2c0;
		elem_t e_r0c1;
		elem_t e_r1c1;
		elem_t e_r2c1;
		elem_t e_r0c2;
		elem_t e_r1c2;
		elem_t e_r2c2;
	} in_t;

	typedef struct packed {
		elem_t inv_r0c0;
		elem_t inv_r1c0;
		elem_t inv_r2c0;
		elem_t inv_r0c1;
		elem_t inv_r1c1;
		elem_t inv_r2c1;
		elem_t inv_r0c2;
		elem_t inv_r1c2;
		elem_t inv_r2c2;
		logic  singular;
		logic  saturated;
	} out_t;

endpackage

// ----- sv/matrix_inverse_3x3_top.sv -----
// Top level of the 3x3 fixed-point matrix inverse
// A matrix is taken on every cycle that start is high; busy is always low. Each
// result word appears on result with done high for one cycle, after the
// cofactor pipeline, the determinant pipeline, and a divider that resolves
// one quotient bit per stage (33 stages) with one setup and one clipping
// stage, then the output register.
// A zero determinant returns the identity with singular set.
module matrix_inverse_3x3_top import mi3_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  operand,
	output logic done,
	output out_t result
);

	elem_t          a [3][3];
	logic           cof_vld;
	cof_t           cof_c [3][3];
	elem_t          row0 [3];
	logic           det_vld;
	cof_t           cof_d [3][3];
	logic [DAW-1:0] dabs;
	logic           dneg, dzero;
	logic           dv_vld [3][3];
	elem_t          qv [3][3];
	logic           sv_w [3][3];
	logic           sg_w [3][3];
	elem_t          inv [3][3];
	logic           any_sat;
	logic           done_q;
	out_t           result_q;

	assign busy = 1'b0;

	assign a[0][0] = operand.e_r0c0;
	assign a[1][0] = operand.e_r1c0;
	assign a[2][0] = operand.e_r2c0;
	assign a[0][1] = operand.e_r0c1;
	assign a[1][1] = operand.e_r1c1;
	assign a[2][1] = operand.e_r2c1;
	assign a[0][2] = operand.e_r0c2;
	assign a[1][2] = operand.e_r1c2;
	assign a[2][2] = operand.e_r2c2;

	mi3_cofactor u_cof (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.a         (a),
		.out_valid (cof_vld),
		.cof       (cof_c),
		.row0      (row0)
	);

	mi3_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cof_vld),
		.cof       (cof_c),
		.row0      (row0),
		.out_valid (det_vld),
		.cof_out   (cof_d),
		.dabs      (dabs),
		.dneg      (dneg),
		.dzero     (dzero)
	);

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			mi3_div u_div (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (det_vld),
				.cof       (cof_d[r][k]),
				.dabs      (dabs),
				.dneg      (dneg),
				.in_sing   (dzero),
				.out_valid (dv_vld[r][k]),
				.q         (qv[r][k]),
				.sat       (sv_w[r][k]),
				.out_sing  (sg_w[r][k])
			);
			// swap in the identity when the determinant was zero
			assign inv[r][k] = sg_w[r][k] ? ((r == k) ? ID_ONE : elem_t'(0)) : qv[r][k];
		end
	end

	assign any_sat = (sv_w[0][0] | sv_w[1][0] | sv_w[2][0] |
		sv_w[0][1] | sv_w[1][1] | sv_w[2][1] |
		sv_w[0][2] | sv_w[1][2] | sv_w[2][2]) & ~sg_w[0][0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld[0][0];
		end
	end

	always_ff @(posedge clk) begin
		result_q.inv_r0c0  <= inv[0][0];
		result_q.inv_r1c0  <= inv[1][0];
		result_q.inv_r2c0  <= inv[2][0];
		result_q.inv_r0c1  <= inv[0][1];
		result_q.inv_r1c1  <= inv[1][1];
		result_q.inv_r2c1  <= inv[2][1];
		result_q.inv_r0c2  <= inv[0][2];
		result_q.inv_r1c2  <= inv[1][2];
		result_q.inv_r2c2  <= inv[2][2];
		result_q.singular  <= sg_w[0][0];
		result_q.saturated <= any_sat;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- sv/mi3_cofactor.sv -----
// Two-stage cofactor pipeline: element products, then differences
module mi3_cofactor import mi3_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  elem_t a [3][3],
	output logic  out_valid,
	output cof_t  cof [3][3],
	output elem_t row0 [3]
);

	logic         vld_s1, vld_s2;
	cof_t         pa_s1 [3][3];
	cof_t         pb_s1 [3][3];
	elem_t        row0_s1 [3];
	elem_t        row0_s2 [3];
	cof_t         cof_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pa_s1[0][0] <= cof_t'(a[1][1]) * cof_t'(a[2][2]);
		pb_s1[0][0] <= cof_t'(a[1][2]) * cof_t'(a[2][1]);
		pa_s1[0][1] <= cof_t'(a[0][2]) * cof_t'(a[2][1]);
		pb_s1[0][1] <= cof_t'(a[0][1]) * cof_t'(a[2][2]);
		pa_s1[0][2] <= cof_t'(a[0][1]) * cof_t'(a[1][2]);
		pb_s1[0][2] <= cof_t'(a[0][2]) * cof_t'(a[1][1]);
		pa_s1[1][0] <= cof_t'(a[1][2]) * cof_t'(a[2][0]);
		pb_s1[1][0] <= cof_t'(a[1][0]) * cof_t'(a[2][2]);
		pa_s1[1][1] <= cof_t'(a[0][0]) * cof_t'(a[2][2]);
		pb_s1[1][1] <= cof_t'(a[0][2]) * cof_t'(a[2][0]);
		pa_s1[1][2] <= cof_t'(a[0][2]) * cof_t'(a[1][0]);
		pb_s1[1][2] <= cof_t'(a[0][0]) * cof_t'(a[1][2]);
		pa_s1[2][0] <= cof_t'(a[1][0]) * cof_t'(a[2][1]);
		pb_s1[2][0] <= cof_t'(a[1][1]) * cof_t'(a[2][0]);
		pa_s1[2][1] <= cof_t'(a[0][1]) * cof_t'(a[2][0]);
		pb_s1[2][1] <= cof_t'(a[0][0]) * cof_t'(a[2][1]);
		pa_s1[2][2] <= cof_t'(a[0][0]) * cof_t'(a[1][1]);
		pb_s1[2][2] <= cof_t'(a[0][1]) * cof_t'(a[1][0]);
		for (int k = 0; k < 3; k++) begin
			row0_s1[k] <= a[0][k];
			row0_s2[k] <= row0_s1[k];
		end
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				cof_s2[r][k] <= pa_s1[r][k] - pb_s1[r][k];
			end
		end
	end

	assign out_valid = vld_s2;
	assign cof       = cof_s2;
	assign row0      = row0_s2;

endmodule

// ----- sv/mi3_det.sv -----
// Four-stage determinant pipeline, split products, sum, magnitude and sign
module mi3_det import mi3_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  cof_t           cof [3][3],
	input  elem_t          row0 [3],
	output logic           out_valid,
	output cof_t           cof_out [3][3],
	output logic [DAW-1:0] dabs,
	output logic           dneg,
	output logic           dzero
);

	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [PLW-1:0]   pl_s1 [3];
	logic signed [PLW-1:0]   ph_s1 [3];
	logic signed [DETW-1:0]  t_s2 [3];
	logic signed [DETW-1:0]  det_s3;
	logic [DAW-1:0]          dabs_s4;
	logic                    dneg_s4, dzero_s4;
	cof_t                    cof_s1 [3][3];
	cof_t                    cof_s2 [3][3];
	cof_t                    cof_s3 [3][3];
	cof_t                    cof_s4 [3][3];
	logic signed [DETW-1:0]  det_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign det_neg = -det_s3;

	always_ff @(posedge clk) begin
		// split each column-0 cofactor into a low word and a signed high word
		for (int k = 0; k < 3; k++) begin
			pl_s1[k] <= PLW'(row0[k]) *
				PLW'($signed({1'b0, cof[k][0][DATA_WIDTH-1:0]}));
			ph_s1[k] <= PLW'(row0[k]) * PLW'($signed(cof[k][0][CFW-1:DATA_WIDTH]));
			t_s2[k]  <= (DETW'(ph_s1[k]) <<< DATA_WIDTH) + DETW'(pl_s1[k]);
		end
		det_s3   <= t_s2[0] + t_s2[1] + t_s2[2];
		dneg_s4  <= det_s3[DETW-1];
		dzero_s4 <= (det_s3 == '0);
		dabs_s4  <= det_s3[DETW-1] ? det_neg[DAW-1:0] : det_s3[DAW-1:0];
		cof_s1   <= cof;
		cof_s2   <= cof_s1;
		cof_s3   <= cof_s2;
		cof_s4   <= cof_s3;
	end

	assign out_valid = vld_s4;
	assign cof_out   = cof_s4;
	assign dabs      = dabs_s4;
	assign dneg      = dneg_s4;
	assign dzero     = dzero_s4;

endmodule

// ----- sv/mi3_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, rounding and clipping
module mi3_div import mi3_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  cof_t           cof,
	input  logic [DAW-1:0] dabs,
	input  logic           dneg,
	input  logic           in_sing,
	output logic           out_valid,
	output elem_t          q,
	output logic           sat,
	output logic           out_sing
);

	logic [CW-1:0] rem_sk [QW+1];
	logic [CW-1:0] dd_sk  [QW+1];
	logic [QW-1:0] quo_sk [QW+1];
	logic          neg_sk [QW+1];
	logic          sng_sk [QW+1];
	logic          vld_sk [QW+1];

	logic                  cneg;
	cof_t                  cof_neg;
	logic [2*DATA_WIDTH-1:0] cabs;
	logic [QW-1:0]         lim, qsel, qneg;
	logic                  over;
	elem_t                 res_q;
	logic                  sat_q, sng_q, vld_q;

	assign cneg    = cof[CFW-1];
	assign cof_neg = -cof;
	assign cabs    = cneg ? cof_neg[2*DATA_WIDTH-1:0] : cof[2*DATA_WIDTH-1:0];

	// numerator carries the half-divisor so the floor rounds to nearest
	always_ff @(posedge clk) begin
		rem_sk[0] <= (CW'(cabs) << (2 * FRAC_BITS + 1)) + CW'(dabs);
		dd_sk[0]  <= CW'(dabs) << 1;
		quo_sk[0] <= '0;
		neg_sk[0] <= cneg ^ dneg;
		sng_sk[0] <= in_sing;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk[0] <= 1'b0;
		end else begin
			vld_sk[0] <= in_valid;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_bit
		localparam int B = QW - 1 - i;
		logic [CW-1:0] dsh;
		logic          ge;

		assign dsh = dd_sk[i] << B;
		assign ge  = (rem_sk[i] >= dsh);

		always_ff @(posedge clk) begin
			rem_sk[i+1] <= ge ? rem_sk[i] - dsh : rem_sk[i];
			quo_sk[i+1] <= quo_sk[i] | (QW'(ge) << B);
			dd_sk[i+1]  <= dd_sk[i];
			neg_sk[i+1] <= neg_sk[i];
			sng_sk[i+1] <= sng_sk[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[i+1] <= 1'b0;
			end else begin
				vld_sk[i+1] <= vld_sk[i];
			end
		end
	end

	// a set top quotient bit means the quotient is past any limit
	assign lim  = {2'b00, {(DATA_WIDTH-1){1'b1}}} + QW'(neg_sk[QW]);
	assign over = (quo_sk[QW] > lim);
	assign qsel = over ? lim : quo_sk[QW];
	assign qneg = -qsel;

	always_ff @(posedge clk) begin
		res_q <= neg_sk[QW] ? qneg[DATA_WIDTH-1:0] : qsel[DATA_WIDTH-1:0];
		sat_q <= over;
		sng_q <= sng_sk[QW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_sk[QW];
		end
	end

	assign out_valid = vld_q;
	assign q         = res_q;
	assign sat       = sat_q;
	assign out_sing  = sng_q;

endmodule

// ----- sv/mi3_checker.sv -----
// Port-level checks of the 3x3 inverse and their bind to the top level
`include "matrix_inverse_3x3_top_assert.svh"

module mi3_checker import mi3_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input in_t  operand,
	input logic done,
	input out_t result
);

	// every word out stems from a word taken a fixed time before
	`MI3_ASSERT_IMP(a_done_has_start, done, $past(start, PIPE_LAT))
	`MI3_ASSERT(a_never_busy, !busy)
	`MI3_ASSERT_IMP(a_sing_identity, done && result.singular,
		!result.saturated && result.inv_r0c0 == ID_ONE && result.inv_r1c1 == ID_ONE &&
		result.inv_r2c2 == ID_ONE && result.inv_r1c0 == '0 && result.inv_r0c1 == '0)
	`MI3_ASSERT_IMP(a_zero_is_sing, done && $past(operand == '0, PIPE_LAT), result.singular)

endmodule

bind matrix_inverse_3x3_top mi3_checker u_mi3_checker (.*);
